@@ rtl/core/fpc_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for frustum plane culling.
package fpc_pkg;

	localparam int VW         = 32;   // value width, signed Q16.16
	localparam int FB         = 16;   // fraction bits of values
	localparam int NRM_FB     = 30;   // fraction bits of stored normals
	localparam int CW         = VW + 1; // width of a raw plane component
	localparam int PW         = 2 * CW; // multiplier product width
	localparam int AW         = 64;   // accumulator width
	localparam int DVD_W      = 80;   // divider dividend width
	localparam int DIV_STEPS  = DVD_W;
	localparam int SQRT_STEPS = 32;
	localparam int NPLANES    = 6;

	localparam int IN_DATA_W  = 264;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 8;
	localparam int OUT_USER_W = 2;

	localparam logic [2:0] FN_LOAD    = 3'd0;
	localparam logic [2:0] FN_EXTRACT = 3'd1;
	localparam logic [2:0] FN_POINT   = 3'd2;
	localparam logic [2:0] FN_SPHERE  = 3'd3;
	localparam logic [2:0] FN_BOX     = 3'd4;

	localparam logic [1:0] SEL_OFFSET = 2'd3;

	typedef struct packed {
		logic       in_ld;
		logic       mat_wr;
		logic       mat_rd;
		logic [3:0] mat_addr;
		logic       w_ld;
		logic       comp_ld;
		logic [1:0] comp_idx;
		logic       comp_sub;
		logic       norm_init;
		logic       norm_step;
		logic       qmode;
		logic [1:0] mul_sel;
		logic       acc_ld;
		logic       acc_add;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       div_start;
		logic       div_step;
		logic       div_store;
		logic [1:0] div_sel;
		logic       zero_store;
		logic [2:0] plane;
		logic       q_start;
		logic       q_chk;
		logic       out_ld;
	} cmd_t;

	typedef struct packed {
		logic mx_zero;
		logic norm_ok;
	} stat_t;

endpackage

@@ rtl/core/fpc_ctrl.sv @@
// Controller state machine sequencing matrix loads, plane extraction and queries.
module fpc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [2:0]            func,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output fpc_pkg::cmd_t         cmd,
	input  fpc_pkg::stat_t        st
);
	import fpc_pkg::*;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_EX_RD     = 4'd1;
	localparam logic [3:0] ST_NORM_INIT = 4'd2;
	localparam logic [3:0] ST_NORM      = 4'd3;
	localparam logic [3:0] ST_SQ        = 4'd4;
	localparam logic [3:0] ST_SQRT_INIT = 4'd5;
	localparam logic [3:0] ST_SQRT      = 4'd6;
	localparam logic [3:0] ST_DIV_INIT  = 4'd7;
	localparam logic [3:0] ST_DIV       = 4'd8;
	localparam logic [3:0] ST_DIV_STORE = 4'd9;
	localparam logic [3:0] ST_Q         = 4'd10;
	localparam logic [3:0] ST_OUT       = 4'd11;

	logic [3:0] state_q, state_d;
	logic [2:0] p_q, p_d;
	logic [1:0] j_q, j_d;
	logic [1:0] ph_q, ph_d;
	logic [6:0] cnt_q, cnt_d;
	logic [1:0] di_q, di_d;
	logic       mval_q, mval_d;
	logic       last_plane;

	assign last_plane = (p_q == 3'(NPLANES - 1));
	assign m_tvalid   = mval_q;

	always_comb begin
		state_d  = state_q;
		p_d      = p_q;
		j_d      = j_q;
		ph_d     = ph_q;
		cnt_d    = cnt_q;
		di_d     = di_q;
		cmd      = '0;
		s_tready = 1'b0;
		cmd.plane = p_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.in_ld = 1'b1;
					p_d       = '0;
					j_d       = '0;
					ph_d      = '0;
					cnt_d     = '0;
					case (func)
						FN_LOAD:    cmd.mat_wr = 1'b1;
						FN_EXTRACT: state_d = ST_EX_RD;
						FN_POINT, FN_SPHERE, FN_BOX: begin
							cmd.q_start = 1'b1;
							state_d     = ST_Q;
						end
						default: ;
					endcase
				end
			end
			ST_EX_RD: begin
				// Each component takes a read of the w row, a read of the axis row, then a combine.
				cmd.mat_rd   = (ph_q != 2'd2);
				cmd.mat_addr = (ph_q == 2'd0) ? {j_q, 2'd3} : {j_q, p_q[2:1]};
				cmd.w_ld     = (ph_q == 2'd1);
				cmd.comp_idx = j_q;
				cmd.comp_sub = p_q[0];
				if (ph_q == 2'd2) begin
					cmd.comp_ld = 1'b1;
					ph_d        = '0;
					if (j_q == 2'd3) begin
						state_d = ST_NORM_INIT;
					end else begin
						j_d = j_q + 2'd1;
					end
				end else begin
					ph_d = ph_q + 2'd1;
				end
			end
			ST_NORM_INIT: begin
				cmd.norm_init = 1'b1;
				state_d       = ST_NORM;
			end
			ST_NORM: begin
				if (st.mx_zero) begin
					cmd.zero_store = 1'b1;
					if (last_plane) begin
						state_d = ST_IDLE;
					end else begin
						p_d     = p_q + 3'd1;
						j_d     = '0;
						ph_d    = '0;
						state_d = ST_EX_RD;
					end
				end else if (st.norm_ok) begin
					cnt_d   = '0;
					state_d = ST_SQ;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			ST_SQ: begin
				cmd.mul_sel = cnt_q[1:0];
				cmd.acc_ld  = (cnt_q == 7'd1);
				cmd.acc_add = (cnt_q == 7'd2) || (cnt_q == 7'd3);
				if (cnt_q == 7'd3) begin
					state_d = ST_SQRT_INIT;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			ST_SQRT_INIT: begin
				cmd.sqrt_init = 1'b1;
				cnt_d         = '0;
				state_d       = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == 7'(SQRT_STEPS - 1)) begin
					di_d    = '0;
					state_d = ST_DIV_INIT;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			ST_DIV_INIT: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = di_q;
				cnt_d         = '0;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 7'(DIV_STEPS - 1)) begin
					state_d = ST_DIV_STORE;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			ST_DIV_STORE: begin
				cmd.div_store = 1'b1;
				cmd.div_sel   = di_q;
				if (di_q == SEL_OFFSET) begin
					if (last_plane) begin
						state_d = ST_IDLE;
					end else begin
						p_d     = p_q + 3'd1;
						j_d     = '0;
						ph_d    = '0;
						state_d = ST_EX_RD;
					end
				end else begin
					di_d    = di_q + 2'd1;
					state_d = ST_DIV_INIT;
				end
			end
			ST_Q: begin
				cmd.qmode   = 1'b1;
				cmd.mul_sel = cnt_q[1:0];
				cmd.acc_ld  = (cnt_q == 7'd1);
				cmd.acc_add = (cnt_q == 7'd2) || (cnt_q == 7'd3);
				cmd.q_chk   = (cnt_q == 7'd4);
				if (cnt_q == 7'd4) begin
					cnt_d = '0;
					if (last_plane) begin
						state_d = ST_OUT;
					end else begin
						p_d = p_q + 3'd1;
					end
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			ST_OUT: begin
				if (!mval_q || m_tready) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		if (cmd.out_ld) begin
			mval_d = 1'b1;
		end else if (m_tready) begin
			mval_d = 1'b0;
		end else begin
			mval_d = mval_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			p_q     <= '0;
			j_q     <= '0;
			ph_q    <= '0;
			cnt_q   <= '0;
			di_q    <= '0;
			mval_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			p_q     <= p_d;
			j_q     <= j_d;
			ph_q    <= ph_d;
			cnt_q   <= cnt_d;
			di_q    <= di_d;
			mval_q  <= mval_d;
		end
	end

endmodule

@@ rtl/core/fpc_dp.sv @@
// Datapath: matrix memory, plane registers, shared multiplier, square root and divider.
module fpc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [fpc_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic [fpc_pkg::IN_USER_W-1:0]      s_tuser,
	input  fpc_pkg::cmd_t                      cmd,
	output fpc_pkg::stat_t                     st,
	output logic [fpc_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [fpc_pkg::OUT_USER_W-1:0]     m_tuser
);
	import fpc_pkg::*;

	// Input word fields.
	logic [3:0]           in_idx;
	logic [VW-1:0]        in_val;
	logic signed [VW-1:0] in_a [3];
	logic signed [VW-1:0] in_b [3];
	logic [VW-2:0]        in_r;

	assign in_idx  = s_tdata[3:0];
	assign in_val  = s_tdata[35:4];
	assign in_a[0] = s_tdata[67:36];
	assign in_a[1] = s_tdata[99:68];
	assign in_a[2] = s_tdata[131:100];
	assign in_b[0] = s_tdata[163:132];
	assign in_b[1] = s_tdata[195:164];
	assign in_b[2] = s_tdata[227:196];
	assign in_r    = s_tdata[258:228];

	logic [2:0]           func_q;
	logic signed [VW-1:0] a_q [3];
	logic signed [VW-1:0] b_q [3];
	logic [VW-2:0]        r_q;

	logic [VW-1:0]        mat_mem [16];
	logic [VW-1:0]        rdata_q;
	logic signed [VW-1:0] w_q;
	logic signed [CW-1:0] comp_q [4];

	logic [CW-1:0]        m_q [3];
	logic [CW-1:0]        mx_q;
	logic signed [6:0]    sc_q;

	logic signed [PW-1:0] prod_s1;
	logic signed [AW-1:0] acc_q;

	logic [63:0]          sq_x_q, sq_res_q, sq_bit_q;

	logic [DVD_W-1:0]     dvd_q;
	logic [VW-1:0]        rem_q;
	logic [VW-2:0]        quo_q;
	logic                 ovf_q;

	logic signed [VW-1:0] n_q [NPLANES][3];
	logic signed [VW-1:0] off_q [NPLANES];

	logic inside_q, inside_o_q;
	logic [1:0] kind_q;

	// Input latch and matrix memory.
	always_ff @(posedge clk) begin
		if (cmd.in_ld) begin
			func_q <= s_tuser;
			a_q    <= in_a;
			b_q    <= in_b;
			r_q    <= in_r;
		end
		if (cmd.mat_wr) begin
			mat_mem[in_idx] <= in_val;
		end
		if (cmd.mat_rd) begin
			rdata_q <= mat_mem[cmd.mat_addr];
		end
	end

	// Plane components: w row plus or minus the axis row.
	logic signed [CW-1:0] w_ext, e_ext;
	assign w_ext = CW'(w_q);
	assign e_ext = CW'($signed(rdata_q));

	always_ff @(posedge clk) begin
		if (cmd.w_ld) begin
			w_q <= rdata_q;
		end
		if (cmd.comp_ld) begin
			comp_q[cmd.comp_idx] <= cmd.comp_sub ? (w_ext - e_ext) : (w_ext + e_ext);
		end
	end

	// Normalization: step the three normal magnitudes by one bit until the largest lies in [2^29, 2^30).
	logic [CW-1:0] mag [4];
	logic [CW-1:0] mag_max;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag[i] = comp_q[i][CW-1] ? CW'(-comp_q[i]) : CW'(comp_q[i]);
		end
		mag_max = mag[0];
		if (mag[1] > mag_max) mag_max = mag[1];
		if (mag[2] > mag_max) mag_max = mag[2];
	end

	logic mx_big;
	assign mx_big     = |mx_q[CW-1:NRM_FB];
	assign st.mx_zero = (mx_q == '0);
	assign st.norm_ok = !mx_big && mx_q[NRM_FB-1];

	always_ff @(posedge clk) begin
		if (cmd.norm_init) begin
			for (int i = 0; i < 3; i++) m_q[i] <= mag[i];
			mx_q <= mag_max;
			sc_q <= '0;
		end else if (cmd.norm_step) begin
			if (mx_big) begin
				for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				mx_q <= mx_q >> 1;
				sc_q <= sc_q - 7'sd1;
			end else begin
				for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
				mx_q <= mx_q << 1;
				sc_q <= sc_q + 7'sd1;
			end
		end
	end

	// Shared multiplier: normal times coordinate for queries, squares during extraction.
	logic signed [VW-1:0] n_sel;
	logic signed [VW-1:0] v_sel;
	logic [CW-1:0]        m_sel;
	logic signed [CW-1:0] mul_a, mul_b;
	logic                 is_box, is_sphere;

	assign is_box    = (func_q == FN_BOX);
	assign is_sphere = (func_q == FN_SPHERE);

	always_comb begin
		case (cmd.mul_sel)
			2'd0: begin
				n_sel = n_q[cmd.plane][0];
				v_sel = (is_box && n_sel[VW-1]) ? b_q[0] : a_q[0];
				m_sel = m_q[0];
			end
			2'd1: begin
				n_sel = n_q[cmd.plane][1];
				v_sel = (is_box && n_sel[VW-1]) ? b_q[1] : a_q[1];
				m_sel = m_q[1];
			end
			2'd2: begin
				n_sel = n_q[cmd.plane][2];
				v_sel = (is_box && n_sel[VW-1]) ? b_q[2] : a_q[2];
				m_sel = m_q[2];
			end
			default: begin
				n_sel = '0;
				v_sel = '0;
				m_sel = '0;
			end
		endcase
		if (cmd.qmode) begin
			mul_a = CW'(n_sel);
			mul_b = CW'(v_sel);
		end else begin
			mul_a = $signed(m_sel);
			mul_b = $signed(m_sel);
		end
	end

	logic signed [PW-1:0] prod_sh;
	logic signed [AW-1:0] term, acc_base, acc_sph;
	assign prod_sh  = prod_s1 >>> NRM_FB;
	assign term     = cmd.qmode ? prod_sh[AW-1:0] : prod_s1[AW-1:0];
	assign acc_base = cmd.qmode ? AW'(off_q[cmd.plane]) : '0;
	assign acc_sph  = acc_q + $signed(AW'(r_q));

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (cmd.acc_ld) begin
			acc_q <= acc_base + term;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + term;
		end
	end

	// Bit-pair square root of the sum of squares, one result bit per cycle.
	logic [63:0] sq_t;
	assign sq_t = sq_res_q + sq_bit_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			sq_x_q   <= acc_q;
			sq_res_q <= '0;
			sq_bit_q <= 64'd1 << 62;
		end else if (cmd.sqrt_step) begin
			if (sq_x_q >= sq_t) begin
				sq_x_q   <= sq_x_q - sq_t;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// Restoring divider by the normal length; quotient bits above bit 30 saturate.
	logic [VW-2:0]  len;
	logic [VW-1:0]  div_t;
	logic           div_ge;
	logic [CW-1:0]  dm;
	logic [6:0]     kk;
	logic [DVD_W-1:0] dvd_init;

	assign len    = sq_res_q[VW-2:0];
	assign div_t  = {rem_q[VW-2:0], dvd_q[DVD_W-1]};
	assign div_ge = (div_t >= {1'b0, len});
	assign dm     = mag[3];
	assign kk     = 7'(FB) + sc_q;

	always_comb begin
		case (cmd.div_sel)
			2'd0:    dvd_init = DVD_W'(m_q[0][NRM_FB-1:0]) << NRM_FB;
			2'd1:    dvd_init = DVD_W'(m_q[1][NRM_FB-1:0]) << NRM_FB;
			2'd2:    dvd_init = DVD_W'(m_q[2][NRM_FB-1:0]) << NRM_FB;
			default: dvd_init = DVD_W'(dm) << kk;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= dvd_init;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? (div_t - {1'b0, len}) : div_t;
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[VW-3:0], div_ge};
			ovf_q <= ovf_q | quo_q[VW-2];
		end
	end

	logic [VW-2:0]        div_res;
	logic signed [VW-1:0] div_pos;
	logic                 div_neg;
	logic signed [VW-1:0] div_val;
	assign div_res = ovf_q ? '1 : quo_q;
	assign div_pos = $signed({1'b0, div_res});
	assign div_neg = comp_q[cmd.div_sel][CW-1];
	assign div_val = div_neg ? -div_pos : div_pos;

	// Plane registers, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NPLANES; p++) begin
				for (int i = 0; i < 3; i++) n_q[p][i] <= '0;
				off_q[p] <= '0;
			end
		end else if (cmd.zero_store) begin
			for (int i = 0; i < 3; i++) n_q[cmd.plane][i] <= '0;
			off_q[cmd.plane] <= '0;
		end else if (cmd.div_store) begin
			if (cmd.div_sel == SEL_OFFSET) begin
				off_q[cmd.plane] <= div_val;
			end else begin
				n_q[cmd.plane][cmd.div_sel] <= div_val;
			end
		end
	end

	// Query verdict and result register.
	logic fail;
	assign fail = is_sphere ? acc_sph[AW-1] : acc_q[AW-1];

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			inside_q <= 1'b1;
		end else if (cmd.q_chk && fail) begin
			inside_q <= 1'b0;
		end
		if (cmd.out_ld) begin
			inside_o_q <= inside_q;
			kind_q     <= 2'(func_q - FN_POINT);
		end
	end

	assign m_tdata = {(OUT_DATA_W - 1)'(0), inside_o_q};
	assign m_tuser = kind_q;

endmodule

@@ rtl/core/frustum_plane_culling_top.sv @@
// Top level of the frustum plane culling block.
// A load word writes one matrix element. A point, sphere or box query walks the six
// stored planes with the shared multiplier, then waits for the result register to drain.
// An extract word handles the six planes in turn; the time per plane depends on how far
// the normalization has to shift and is set mostly by the one-bit-per-cycle divider that
// runs 80 steps for each of the three normal components and the offset, after a 32-step
// square root; a plane with a zero normal is stored as zero and skips these steps.
// A query issued before any extract sees all-zero planes, so it passes. Input words are
// taken only while the block is idle; a finished result waits in its own register while the
// next word is accepted.
module frustum_plane_culling_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// mat_index[3:0], mat_value, ax, ay, az, bx, by, bz (32 bits each), radius (31 bits), zeros
	input  logic [fpc_pkg::IN_DATA_W-1:0]     s_tdata,
	// func[2:0]
	input  logic [fpc_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// inside_res[0], zeros
	output logic [fpc_pkg::OUT_DATA_W-1:0]    m_tdata,
	// test_kind[1:0]
	output logic [fpc_pkg::OUT_USER_W-1:0]    m_tuser
);
	import fpc_pkg::*;

	cmd_t  cmd;
	stat_t st;

	fpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

	fpc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.st      (st),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
